@@ src/wsd_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer.
// Used by wsd_in_reg, wsd_parse and websocket_frame_deframer; depends on nothing.
package wsd_pkg;

   // Header store geometry: the longest header is 2 + 8 + 4 bytes
   localparam int HEADER_BYTES = 14;
   localparam int HDR_IDX_W    = 4;

   // Length codes carried in the low seven bits of header byte 1
   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   // Bit position of FIN in byte 0 and of MASK in byte 1
   localparam int FLAG_BIT = 7;

   // Reset values of the limit registers
   localparam logic [31:0] MAX_MESSAGE_RESET   = 32'd65536;
   localparam logic [15:0] MAX_FRAGMENTS_RESET = 16'd1024;

   // Configuration register indexes
   localparam int            CSR_INDEX_W       = 1;
   localparam logic [0:0]    CSR_MAX_MESSAGE   = 1'b0;
   localparam logic [0:0]    CSR_MAX_FRAGMENTS = 1'b1;

   // One result word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       frame_end;
      logic       message_end;
      logic       drop_connection;
   } result_type;

   // Limits as programmed through the configuration port
   typedef struct packed {
      logic [31:0] max_message;
      logic [15:0] max_fragments;
   } limits_type;

   // Parser status seen by the top level
   typedef struct packed {
      logic dropped;
      logic in_payload;
   } status_type;

endpackage

@@ src/websocket_frame_deframer.sv @@
// WebSocket frame deframer, top level: ports, limit registers and checks.
// Depends on wsd_pkg, wsd_in_reg and wsd_parse.
//
// Usage: raw connection bytes enter on the req_ stream, one byte per word.
// Each frame header (2 to 14 bytes) is collected and gives no word, except
// for a zero-length frame, which yields one word with tlast set on its last
// header byte, and an oversized frame, which yields a drop word. Payload
// bytes come out unmasked on the rsp_ stream with tuser (byte valid) set
// and tlast on the last byte of a frame; tdata[8] marks the end of a
// message. When the message size or fragment limit is exceeded, tdata[9]
// is set and from then on every input byte yields a word that carries only
// that flag, until reset. Throughput: one byte per cycle unless rsp_
// stalls, set by the single pass between the input register and the result
// register; a stalled result register blocks the input register, which
// drops req_tready once full. Limits must be written on the csr_ port
// while the stream is idle; the block does not enforce it. Reset restores
// 65536 bytes and 1024 fragments and returns to header collection.
module websocket_frame_deframer #(
   parameter int SIZE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] message_end,
                                    // [9] drop_connection, [15:10] zero
   output logic        rsp_tuser,   // [0] byte_valid
   output logic        rsp_tlast,   // frame_end
   // Configuration write port
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wsd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                      csr_data
);
   import wsd_pkg::*;

   logic       in_valid;
   logic [7:0] in_byte;
   logic       in_take;
   limits_type limits_ff;
   result_type rsp;
   status_type status;

   // Limit registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.max_message   <= MAX_MESSAGE_RESET;
         limits_ff.max_fragments <= MAX_FRAGMENTS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_MESSAGE:   limits_ff.max_message   <= csr_data;
            CSR_MAX_FRAGMENTS: limits_ff.max_fragments <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   wsd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .in_valid   (in_valid),
      .in_byte    (in_byte),
      .in_take    (in_take)
   );

   wsd_parse #(
      .SIZE_BITS (SIZE_BITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_byte   (in_byte),
      .in_take   (in_take),
      .limits    (limits_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp),
      .status    (status)
   );

   // Pack the result word
   assign rsp_tdata = {6'd0, rsp.drop_connection, rsp.message_end, rsp.out_byte};
   assign rsp_tuser = rsp.byte_valid;
   assign rsp_tlast = rsp.frame_end;

   // Drop holds until reset
   a_drop_sticky: assert property (@(posedge clock) disable iff (reset)
      status.dropped |=> status.dropped)
      else $error("drop state cleared without reset");

   // A message end only comes with a frame end
   a_msg_end_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tlast)
      else $error("message end without frame end");

   // A payload byte carries a drop only when it closes its frame
   a_drop_on_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tdata[9] |-> rsp_tlast)
      else $error("drop on a payload byte inside a frame");

endmodule

@@ src/wsd_in_reg.sv @@
// Input register of the WebSocket frame deframer: holds one received byte.
// Depends on wsd_pkg (nothing used beyond the import).
module wsd_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   output logic       in_valid,
   output logic [7:0] in_byte,
   input  logic       in_take
);
   import wsd_pkg::*;

   logic       valid_ff;
   logic [7:0] byte_ff;

   // Accept a new word when empty or when the held one moves on this cycle
   assign req_tready = !valid_ff || in_take;
   assign in_valid   = valid_ff;
   assign in_byte    = byte_ff;

   // Hold valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
   end

   // Capture the byte on acceptance
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
      end
   end

endmodule

@@ src/wsd_parse.sv @@
// Frame parser of the WebSocket deframer: header collection, length, size and
// fragment checks, payload unmasking and the result register. Depends on wsd_pkg.
module wsd_parse #(
   parameter int SIZE_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [7:0]          in_byte,
   output logic                in_take,
   input  wsd_pkg::limits_type limits,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output wsd_pkg::result_type rsp,
   output wsd_pkg::status_type status
);
   import wsd_pkg::*;

   // Header bytes of the current frame
   logic [7:0]           hdr_ff [HEADER_BYTES];
   logic [HDR_IDX_W-1:0] hdr_count_ff, hdr_count_in;
   logic                 in_payload_ff, in_payload_in;
   logic                 final_ff, final_in;
   logic                 masked_ff, masked_in;
   logic [31:0]          key_ff, key_in;
   logic [31:0]          flen_ff, flen_in;
   logic [SIZE_BITS-1:0] pos_ff, pos_in;
   logic [SIZE_BITS-1:0] msize_ff, msize_in;
   logic [15:0]          frag_ff, frag_in;
   logic                 dropped_ff, dropped_in;
   logic                 rsp_valid_ff;
   result_type           rsp_ff;

   logic                 fire;
   logic [HDR_IDX_W-1:0] hc_base, hc_new, need;
   logic [7:0]           view [HEADER_BYTES];
   logic [6:0]           code;
   logic                 masked_new, final_new;
   logic                 hdr_done;
   logic [31:0]          len32, key_new, room;
   logic                 len_hi_nz, too_big, zero_len;
   logic [31:0]          fin_len;
   logic                 fin_final;
   logic [SIZE_BITS-1:0] msize_sum, pos_next;
   logic [15:0]          frag_inc;
   logic                 frag_drop, pay_end, do_finish;
   logic [7:0]           key_byte;
   logic                 has_res;
   result_type           res;

   // Advance when a byte waits and the result register is free or draining
   assign fire    = in_valid && (!rsp_valid_ff || rsp_ready);
   assign in_take = fire;

   // Header view: stored bytes with the incoming byte in its slot
   always_comb begin
      hc_base = (hdr_count_ff >= HDR_IDX_W'(HEADER_BYTES)) ? '0 : hdr_count_ff;
      hc_new  = hc_base + HDR_IDX_W'(1);
      for (int i = 0; i < HEADER_BYTES; i++) begin
         view[i] = (HDR_IDX_W'(i) == hc_base) ? in_byte : hdr_ff[i];
      end
   end

   // Decode header layout
   always_comb begin
      code       = view[1][6:0];
      masked_new = view[1][FLAG_BIT];
      final_new  = view[0][FLAG_BIT];
      need       = HDR_IDX_W'(2);
      if (code == LEN_CODE_16) begin
         need = need + HDR_IDX_W'(2);
      end else if (code == LEN_CODE_64) begin
         need = need + HDR_IDX_W'(8);
      end
      if (masked_new) begin
         need = need + HDR_IDX_W'(4);
      end
      hdr_done = (hc_new >= HDR_IDX_W'(2)) && (hc_new >= need);
   end

   // Extract frame length and mask key
   always_comb begin
      priority if (code == LEN_CODE_16) begin
         len32     = {16'd0, view[2], view[3]};
         len_hi_nz = 1'b0;
         key_new   = {view[4], view[5], view[6], view[7]};
      end else if (code == LEN_CODE_64) begin
         len32     = {view[6], view[7], view[8], view[9]};
         len_hi_nz = |{view[2], view[3], view[4], view[5]};
         key_new   = {view[10], view[11], view[12], view[13]};
      end else begin
         len32     = {25'd0, code};
         len_hi_nz = 1'b0;
         key_new   = {view[2], view[3], view[4], view[5]};
      end
      if (!masked_new) begin
         key_new = '0;
      end
   end

   // Size check without wrap
   always_comb begin
      room     = limits.max_message - len32;
      too_big  = len_hi_nz || (len32 > limits.max_message)
                 || (64'(msize_ff) > 64'(room));
      zero_len = !len_hi_nz && (len32 == 32'd0);
   end

   // Frame completion bookkeeping, shared by zero-length and payload ends
   always_comb begin
      fin_len   = in_payload_ff ? flen_ff : len32;
      fin_final = in_payload_ff ? final_ff : final_new;
      msize_sum = SIZE_BITS'(64'(msize_ff) + 64'(fin_len));
      frag_inc  = (frag_ff == 16'hFFFF) ? frag_ff : frag_ff + 16'd1;
      frag_drop = !fin_final && (frag_inc >= limits.max_fragments);
   end

   // Payload unmasking and end detection
   always_comb begin
      unique case (pos_ff[1:0])
         2'd0: key_byte = key_ff[31:24];
         2'd1: key_byte = key_ff[23:16];
         2'd2: key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      pos_next = pos_ff + SIZE_BITS'(1);
      pay_end  = 64'(pos_next) >= 64'(flen_ff);
   end

   // Next state and result
   always_comb begin
      hdr_count_in  = hdr_count_ff;
      in_payload_in = in_payload_ff;
      final_in      = final_ff;
      masked_in     = masked_ff;
      key_in        = key_ff;
      flen_in       = flen_ff;
      pos_in        = pos_ff;
      msize_in      = msize_ff;
      frag_in       = frag_ff;
      dropped_in    = dropped_ff;
      do_finish     = 1'b0;
      has_res       = 1'b0;
      res           = '0;
      if (fire) begin
         if (dropped_ff) begin
            has_res             = 1'b1;
            res.drop_connection = 1'b1;
         end else if (!in_payload_ff) begin
            hdr_count_in = hc_new;
            if (hdr_done) begin
               final_in  = final_new;
               masked_in = masked_new;
               flen_in   = len32;
               key_in    = key_new;
               pos_in    = '0;
               priority if (too_big) begin
                  dropped_in          = 1'b1;
                  has_res             = 1'b1;
                  res.drop_connection = 1'b1;
               end else if (zero_len) begin
                  do_finish       = 1'b1;
                  has_res         = 1'b1;
                  res.frame_end   = 1'b1;
                  res.message_end = final_new;
               end else begin
                  in_payload_in = 1'b1;
               end
            end
         end else begin
            pos_in         = pos_next;
            has_res        = 1'b1;
            res.out_byte   = in_byte ^ (masked_ff ? key_byte : 8'd0);
            res.byte_valid = 1'b1;
            if (pay_end) begin
               do_finish       = 1'b1;
               res.frame_end   = 1'b1;
               res.message_end = final_ff;
            end
         end
         // Close the frame: grow or clear message size, count fragments
         if (do_finish) begin
            msize_in      = fin_final ? '0 : msize_sum;
            frag_in       = fin_final ? 16'd0 : frag_inc;
            hdr_count_in  = '0;
            in_payload_in = 1'b0;
            if (frag_drop) begin
               dropped_in          = 1'b1;
               res.drop_connection = 1'b1;
            end
         end
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_count_ff  <= '0;
         in_payload_ff <= 1'b0;
         final_ff      <= 1'b0;
         masked_ff     <= 1'b0;
         key_ff        <= '0;
         flen_ff       <= '0;
         pos_ff        <= '0;
         msize_ff      <= '0;
         frag_ff       <= '0;
         dropped_ff    <= 1'b0;
      end else begin
         hdr_count_ff  <= hdr_count_in;
         in_payload_ff <= in_payload_in;
         final_ff      <= final_in;
         masked_ff     <= masked_in;
         key_ff        <= key_in;
         flen_ff       <= flen_in;
         pos_ff        <= pos_in;
         msize_ff      <= msize_in;
         frag_ff       <= frag_in;
         dropped_ff    <= dropped_in;
      end
   end

   // Header store: write the incoming header byte into its slot
   always_ff @(posedge clock) begin
      if (fire && !dropped_ff && !in_payload_ff) begin
         hdr_ff[hc_base] <= in_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= has_res;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && has_res) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp               = rsp_ff;
   assign status.dropped    = dropped_ff;
   assign status.in_payload = in_payload_ff;

endmodule
